FILE: rtl/assert_macros.svh
// assertion macros for the sandpile grid toppler
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define SGT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define SGT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/sgt_pkg.sv
// shared types and constants of the sandpile grid toppler
package sgt_pkg;

	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_PERIODIC = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ASYNC    = 1'd1;

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_SWEEP = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		NBR_UP    = 2'd0,
		NBR_RIGHT = 2'd1,
		NBR_DOWN  = 2'd2,
		NBR_LEFT  = 2'd3
	} nbr_t;

	typedef enum logic [1:0] {
		ASEL_REQ,
		ASEL_CTR,
		ASEL_NBR
	} addr_sel_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_ZERO,
		WR_INC,
		WR_SUB4
	} wr_kind_t;

	typedef struct packed {
		cmd_t        command;
		logic [11:0] site_index;
	} req_t;

	typedef struct packed {
		logic        toppled;
		logic [31:0] grain_total;
		logic [7:0]  site_height;
	} rsp_t;

	typedef struct packed {
		logic      req_load;
		logic      ctr_clr;
		logic      ctr_inc;
		logic      nbr_clr;
		logic      nbr_inc;
		addr_sel_t addr_sel;
		logic      rd_h;
		logic      rd_m;
		wr_kind_t  wr_kind;
		logic      mk_wr;
		logic      any_clr;
		logic      any_set;
		logic      hgt_clr;
		logic      hgt_ld;
		logic      cnt_up;
		logic      cnt_dn;
	} dp_cmd_t;

	typedef struct packed {
		cmd_t command;
		logic in_range;
		logic ctr_last;
		logic nbr_last;
		logic h_ge4;
		logic h_max;
		logic mark;
		logic nbr_edge;
		logic periodic;
		logic async_on;
	} dp_sts_t;

endpackage

FILE: rtl/sandpile_grid_toppler.sv
// top level of the sandpile grid toppler
// add, read (site in range): decode, read, write-back, done, next request then
// sweep: a mark pass over all sites when not in async mode, then a topple pass;
//   toppled sites visit four neighbours, all on the single height memory port
// after reset a clearing pass zeroes every height of the grid, busy stays high
// results are strobed for one cycle by done and cannot be held off
module sandpile_grid_toppler #(
	parameter int SIDE        = 64,
	parameter int HEIGHT_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  sgt_pkg::req_t                 req,
	output logic                          done,
	output sgt_pkg::rsp_t                 rsp,
	input  logic                          cfg_we,
	input  logic [sgt_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic                          cfg_data
);
	import sgt_pkg::*;
	`include "assert_macros.svh"

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	sgt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.sts    (dp_sts),
		.cmd    (dp_cmd)
	);

	sgt_dp #(
		.SIDE        (SIDE),
		.HEIGHT_BITS (HEIGHT_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cmd      (dp_cmd),
		.sts      (dp_sts),
		.rsp      (rsp)
	);

	`SGT_NEVER(a_done_while_busy, done && busy, "result strobed while busy")
	`SGT_ASSERT(a_accept_busy, (start && !busy) |=> busy, "request not taken")
	`SGT_ASSERT(a_done_single, done |=> !done, "result strobe longer than one cycle")
	`SGT_NEVER(a_sweep_height, done && rsp.toppled && rsp.site_height != 8'd0,
		"sweep result carries a height")

endmodule

FILE: rtl/sgt_dp.sv
// datapath: height and mark memories, site counters, grain count, result registers
module sgt_dp #(
	parameter int SIDE        = 64,
	parameter int HEIGHT_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sgt_pkg::req_t                 req,
	input  logic                          cfg_we,
	input  logic [sgt_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic                          cfg_data,
	input  sgt_pkg::dp_cmd_t              cmd,
	output sgt_pkg::dp_sts_t              sts,
	output sgt_pkg::rsp_t                 rsp
);
	import sgt_pkg::*;

	localparam int NSITES = SIDE * SIDE;
	localparam int AW     = $clog2(NSITES);
	localparam int XW     = $clog2(SIDE);
	localparam int HB     = HEIGHT_BITS;

	logic [HB-1:0] hmem [NSITES];
	logic          mmem [NSITES];

	req_t          req_q;
	logic          periodic_q;
	logic          async_q;
	logic [AW-1:0] ctr_q;
	logic [XW-1:0] x_q;
	logic [XW-1:0] y_q;
	nbr_t          nbr_q;
	logic [HB-1:0] hrd_q;
	logic          mrd_q;
	logic          any_q;
	logic [HB-1:0] height_q;
	logic [31:0]   cnt_q;

	logic [AW-1:0] addr;
	logic [AW-1:0] nbr_addr;
	logic          nbr_edge;
	logic [HB-1:0] wdata;
	logic          x_last;
	logic          y_last;

	assign x_last = (x_q == XW'(SIDE - 1));
	assign y_last = (y_q == XW'(SIDE - 1));

	always_comb begin
		nbr_addr = ctr_q;
		nbr_edge = 1'b0;
		case (nbr_q)
			NBR_UP: begin
				nbr_edge = (y_q == '0);
				nbr_addr = nbr_edge ? AW'(NSITES - SIDE) + AW'(x_q) : ctr_q - AW'(SIDE);
			end
			NBR_RIGHT: begin
				nbr_edge = x_last;
				nbr_addr = nbr_edge ? ctr_q - AW'(SIDE - 1) : ctr_q + AW'(1);
			end
			NBR_DOWN: begin
				nbr_edge = y_last;
				nbr_addr = nbr_edge ? AW'(x_q) : ctr_q + AW'(SIDE);
			end
			NBR_LEFT: begin
				nbr_edge = (x_q == '0);
				nbr_addr = nbr_edge ? ctr_q + AW'(SIDE - 1) : ctr_q - AW'(1);
			end
			default: begin
				nbr_edge = 1'b0;
				nbr_addr = ctr_q;
			end
		endcase
	end

	always_comb begin
		case (cmd.addr_sel)
			ASEL_REQ: addr = AW'(req_q.site_index);
			ASEL_CTR: addr = ctr_q;
			ASEL_NBR: addr = nbr_addr;
			default:  addr = ctr_q;
		endcase
	end

	always_comb begin
		case (cmd.wr_kind)
			WR_INC:  wdata = hrd_q + HB'(1);
			WR_SUB4: wdata = hrd_q - HB'(4);
			default: wdata = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_kind != WR_NONE) begin
			hmem[addr] <= wdata;
		end
		if (cmd.rd_h) begin
			hrd_q <= hmem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mk_wr) begin
			mmem[ctr_q] <= (hrd_q >= HB'(4));
		end
		if (cmd.rd_m) begin
			mrd_q <= mmem[ctr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			req_q <= req;
		end
		if (cmd.hgt_clr) begin
			height_q <= '0;
		end else if (cmd.hgt_ld) begin
			height_q <= (req_q.command == CMD_ADD && hrd_q != '1) ? hrd_q + HB'(1) : hrd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			periodic_q <= 1'b0;
			async_q    <= 1'b0;
			ctr_q      <= '0;
			x_q        <= '0;
			y_q        <= '0;
			nbr_q      <= NBR_UP;
			any_q      <= 1'b0;
			cnt_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_PERIODIC: periodic_q <= cfg_data;
					REG_ASYNC:    async_q    <= cfg_data;
					default:      ;
				endcase
			end
			if (cmd.ctr_clr) begin
				ctr_q <= '0;
				x_q   <= '0;
				y_q   <= '0;
			end else if (cmd.ctr_inc) begin
				ctr_q <= ctr_q + AW'(1);
				if (x_last) begin
					x_q <= '0;
					y_q <= y_q + XW'(1);
				end else begin
					x_q <= x_q + XW'(1);
				end
			end
			if (cmd.nbr_clr) begin
				nbr_q <= NBR_UP;
			end else if (cmd.nbr_inc) begin
				nbr_q <= nbr_t'(nbr_q + 2'd1);
			end
			if (cmd.any_clr) begin
				any_q <= 1'b0;
			end else if (cmd.any_set) begin
				any_q <= 1'b1;
			end
			if (cmd.cnt_up && cnt_q != '1) begin
				cnt_q <= cnt_q + 32'd1;
			end else if (cmd.cnt_dn && cnt_q != '0) begin
				cnt_q <= cnt_q - 32'd1;
			end
		end
	end

	assign sts.command  = req_q.command;
	assign sts.in_range = (32'(req_q.site_index) < 32'(NSITES));
	assign sts.ctr_last = (ctr_q == AW'(NSITES - 1));
	assign sts.nbr_last = (nbr_q == NBR_LEFT);
	assign sts.h_ge4    = (hrd_q >= HB'(4));
	assign sts.h_max    = (hrd_q == '1);
	assign sts.mark     = mrd_q;
	assign sts.nbr_edge = nbr_edge;
	assign sts.periodic = periodic_q;
	assign sts.async_on = async_q;

	assign rsp.toppled     = any_q;
	assign rsp.grain_total = cnt_q;
	assign rsp.site_height = 8'(height_q);

endmodule

FILE: rtl/sgt_ctrl.sv
// controller: command sequencing, clearing pass and sweep state machine
module sgt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output logic             done,
	input  sgt_pkg::dp_sts_t sts,
	output sgt_pkg::dp_cmd_t cmd
);
	import sgt_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_RQ_RD,
		ST_RQ_WB,
		ST_M_RD,
		ST_M_WR,
		ST_T_RD,
		ST_T_CHK,
		ST_N_RD,
		ST_N_WR
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;
	logic   finish;
	logic   topple;

	assign topple = sts.async_on ? sts.h_ge4 : sts.mark;

	always_comb begin
		cmd      = '0;
		cmd.addr_sel = ASEL_CTR;
		cmd.wr_kind  = WR_NONE;
		state_d  = state_q;
		finish   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.wr_kind = WR_ZERO;
				if (sts.ctr_last) begin
					cmd.ctr_clr = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					cmd.ctr_inc = 1'b1;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.req_load = 1'b1;
					state_d      = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.any_clr = 1'b1;
				cmd.hgt_clr = 1'b1;
				cmd.ctr_clr = 1'b1;
				case (sts.command)
					CMD_ADD, CMD_READ: begin
						if (sts.in_range) begin
							state_d = ST_RQ_RD;
						end else begin
							finish = 1'b1;
						end
					end
					CMD_SWEEP: state_d = sts.async_on ? ST_T_RD : ST_M_RD;
					default:   finish = 1'b1;
				endcase
			end
			ST_RQ_RD: begin
				cmd.addr_sel = ASEL_REQ;
				cmd.rd_h     = 1'b1;
				state_d      = ST_RQ_WB;
			end
			ST_RQ_WB: begin
				cmd.addr_sel = ASEL_REQ;
				cmd.hgt_ld   = 1'b1;
				if (sts.command == CMD_ADD && !sts.h_max) begin
					cmd.wr_kind = WR_INC;
					cmd.cnt_up  = 1'b1;
				end
				finish = 1'b1;
			end
			ST_M_RD: begin
				cmd.rd_h = 1'b1;
				state_d  = ST_M_WR;
			end
			ST_M_WR: begin
				cmd.mk_wr   = 1'b1;
				cmd.any_set = sts.h_ge4;
				if (sts.ctr_last) begin
					cmd.ctr_clr = 1'b1;
					state_d     = ST_T_RD;
				end else begin
					cmd.ctr_inc = 1'b1;
					state_d     = ST_M_RD;
				end
			end
			ST_T_RD: begin
				cmd.rd_h = 1'b1;
				cmd.rd_m = 1'b1;
				state_d  = ST_T_CHK;
			end
			ST_T_CHK: begin
				if (topple) begin
					cmd.wr_kind = WR_SUB4;
					cmd.any_set = 1'b1;
					cmd.nbr_clr = 1'b1;
					state_d     = ST_N_RD;
				end else if (sts.ctr_last) begin
					finish = 1'b1;
				end else begin
					cmd.ctr_inc = 1'b1;
					state_d     = ST_T_RD;
				end
			end
			ST_N_RD, ST_N_WR: begin
				cmd.addr_sel = ASEL_NBR;
				if (state_q == ST_N_RD && !(sts.nbr_edge && !sts.periodic)) begin
					cmd.rd_h = 1'b1;
					state_d  = ST_N_WR;
				end else begin
					if (state_q == ST_N_RD || sts.h_max) begin
						cmd.cnt_dn = 1'b1;
					end else begin
						cmd.wr_kind = WR_INC;
					end
					if (!sts.nbr_last) begin
						cmd.nbr_inc = 1'b1;
						state_d     = ST_N_RD;
					end else if (sts.ctr_last) begin
						finish = 1'b1;
					end else begin
						cmd.ctr_inc = 1'b1;
						state_d     = ST_T_RD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (finish) begin
			state_d = ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule
